// ===== src/dipc_pkg.sv =====
// shared types and constants for the depth image to point cloud core
package dipc_pkg;

   localparam int MaxDim    = 4096;
   localparam int CntW      = $clog2(MaxDim);
   localparam int DimW      = 13;
   localparam int CodeW     = 8;
   localparam int QW        = 31;
   localparam int StepW     = 18;
   localparam int OutW      = 32;
   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int DivSteps  = 31;
   localparam int DivCntW   = 5;

   localparam logic [CodeW-1:0] CODE_NEAR_CLIP = 8'h00;
   localparam logic [CodeW-1:0] CODE_FAR_CLIP  = 8'hFF;
   localparam logic [OutW-1:0]  SAT_POS        = 32'h7FFF_FFFF;
   localparam logic [OutW-1:0]  SAT_NEG        = 32'h8000_0000;
   localparam logic [OutW-1:0]  Q_ONE          = 32'h0001_0000;

   // configuration register indexes
   typedef enum logic [3:0] {
      REG_IMAGE_WIDTH  = 4'd0,
      REG_IMAGE_HEIGHT = 4'd1,
      REG_FAR_PLANE    = 4'd2,
      REG_DEPTH_STEP   = 4'd3,
      REG_TAN_HALF_H   = 4'd4,
      REG_TAN_HALF_V   = 4'd5,
      REG_COL_DELTA    = 4'd6,
      REG_ROW_DELTA    = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [DimW-1:0]  image_width;
      logic [DimW-1:0]  image_height;
      logic [QW-1:0]    far_plane;
      logic [QW-1:0]    depth_step;
      logic [QW-1:0]    tan_half_h;
      logic [QW-1:0]    tan_half_v;
      logic [StepW-1:0] col_delta;
      logic [StepW-1:0] row_delta;
   } cfg_type;

   // one unclipped pixel waiting for the back end
   typedef struct packed {
      logic [CodeW-1:0] code;
      logic [CntW-1:0]  col;
      logic [CntW-1:0]  row;
   } pixel_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DEN,
      B_DIV,
      B_MP,
      B_ML,
      B_MH,
      B_OUT
   } back_state_type;

endpackage

// ===== src/depth_image_to_point_cloud_core.sv =====
// top level of the depth image to point cloud core
//
//  channel | ports               | payload
//  req     | req_tvalid/tready   | req_tdata[7:0] depth_code
//  rsp     | rsp_tvalid/tready   | rsp_tdata x_pos, y_pos, z_pos
//  csr     | csr_valid/ready     | csr_index, csr_data
//
// clipped pixels only advance the counters
// an unclipped pixel runs through the back end (1 fetch, 1 denominator,
// 31 division steps, 6 multiply steps over one shared multiplier) and then
// loads the result register; a saturated depth skips the division steps
// reset is synchronous; a four-entry queue lets requests arrive while the back works
// the result register holds while rsp_tvalid is high and rsp_tready is low
module depth_image_to_point_cloud_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] depth_code
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // [31:0] x_pos, [63:32] y_pos, [95:64] z_pos
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [30:0]  csr_data
);

   dipc_pkg::cfg_type   cfg_ff, cfg_in;
   dipc_pkg::pixel_type push_data, pop_data;
   logic                push, pop, fifo_full, fifo_not_empty;
   logic [31:0]         x_pos, y_pos, z_pos;

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dipc_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[12:0];
            dipc_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr_data[12:0];
            dipc_pkg::REG_FAR_PLANE:    cfg_in.far_plane    = csr_data;
            dipc_pkg::REG_DEPTH_STEP:   cfg_in.depth_step   = csr_data;
            dipc_pkg::REG_TAN_HALF_H:   cfg_in.tan_half_h   = csr_data;
            dipc_pkg::REG_TAN_HALF_V:   cfg_in.tan_half_v   = csr_data;
            dipc_pkg::REG_COL_DELTA:    cfg_in.col_delta    = csr_data[17:0];
            dipc_pkg::REG_ROW_DELTA:    cfg_in.row_delta    = csr_data[17:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width: 13'd640, image_height: 13'd480,
                    far_plane: 31'd6553600, depth_step: 31'd25443,
                    tan_half_h: 31'd65536, tan_half_v: 31'd65536,
                    col_delta: 18'd205, row_delta: 18'd274};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dipc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_code   (req_tdata),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_data  (push_data)
   );

   dipc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .not_empty (fifo_not_empty),
      .pop_data  (pop_data)
   );

   dipc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .fifo_not_empty (fifo_not_empty),
      .fifo_data      (pop_data),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .x_pos          (x_pos),
      .y_pos          (y_pos),
      .z_pos          (z_pos)
   );

   assign rsp_tdata = {z_pos, y_pos, x_pos};

endmodule

// ===== src/dipc_front.sv =====
// front end: raster counters and clip classification
module dipc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  dipc_pkg::cfg_type           cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dipc_pkg::CodeW-1:0]  req_code,
   input  logic                        fifo_full,
   output logic                        push,
   output dipc_pkg::pixel_type         push_data
);

   logic [dipc_pkg::CntW-1:0] col_ff, col_in;
   logic [dipc_pkg::CntW-1:0] row_ff, row_in;
   logic [dipc_pkg::CntW:0]   next_col;
   logic [dipc_pkg::CntW:0]   next_row;
   logic                      accept;
   logic                      clipped;

   // accept whenever the queue has room
   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign clipped    = (req_code == dipc_pkg::CODE_NEAR_CLIP) ||
                       (req_code == dipc_pkg::CODE_FAR_CLIP);
   assign push       = accept && !clipped;
   assign push_data  = '{code: req_code, col: col_ff, row: row_ff};

   // column advances on every accepted request; row advances when the column wraps
   always_comb begin
      next_col = {1'b0, col_ff} + 1'b1;
      next_row = {1'b0, row_ff} + 1'b1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (next_col >= cfg.image_width ||
             next_col == (dipc_pkg::CntW+1)'(dipc_pkg::MaxDim)) begin
            col_in = '0;
            if (next_row >= cfg.image_height ||
                next_row == (dipc_pkg::CntW+1)'(dipc_pkg::MaxDim)) begin
               row_in = '0;
            end else begin
               row_in = next_row[dipc_pkg::CntW-1:0];
            end
         end else begin
            col_in = next_col[dipc_pkg::CntW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== src/dipc_fifo.sv =====
// short queue of pixels between front and back end
module dipc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dipc_pkg::pixel_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output dipc_pkg::pixel_type pop_data
);

   dipc_pkg::pixel_type         mem_ff [dipc_pkg::FifoDepth];
   logic [dipc_pkg::FifoAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dipc_pkg::FifoAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dipc_pkg::FifoAw:0]   count_ff, count_in;

   assign full      = count_ff == (dipc_pkg::FifoAw+1)'(dipc_pkg::FifoDepth);
   assign not_empty = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/dipc_back.sv =====
// back end: depth division, projection products and result register
module dipc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dipc_pkg::cfg_type           cfg,
   input  logic                        fifo_not_empty,
   input  dipc_pkg::pixel_type         fifo_data,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dipc_pkg::OutW-1:0]   x_pos,
   output logic [dipc_pkg::OutW-1:0]   y_pos,
   output logic [dipc_pkg::OutW-1:0]   z_pos
);

   dipc_pkg::back_state_type    state_ff, state_in;
   dipc_pkg::pixel_type         pix_ff, pix_in;
   logic [dipc_pkg::QW-1:0]     den_ff, den_in;
   logic [dipc_pkg::OutW-1:0]   rem_ff, rem_in;
   logic [dipc_pkg::QW-1:0]     num_ff, num_in;
   logic [dipc_pkg::QW-1:0]     depth_ff, depth_in;
   logic [dipc_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic [dipc_pkg::OutW-1:0]   u_ff, u_in, v_ff, v_in;
   logic [61:0]                 p_ff, p_in;
   logic                        neg_ff, neg_in;
   logic                        sel_ff, sel_in;
   logic [dipc_pkg::QW-1:0]     lo_ff, lo_in;
   logic [dipc_pkg::OutW-1:0]   y_ff, y_in, z_ff, z_in;
   logic                        out_valid_ff, out_valid_in;
   logic [dipc_pkg::OutW-1:0]   x_out_ff, y_out_ff, z_out_ff;
   logic                        load_out;

   logic [38:0]                 sd;
   logic [40:0]                 den_full;
   logic                        den_sat;
   logic [29:0]                 cu, rv;
   logic [dipc_pkg::OutW-1:0]   rs;
   logic                        fits;
   logic [dipc_pkg::OutW-1:0]   axis;
   logic [dipc_pkg::QW-1:0]     mag;
   logic [dipc_pkg::QW-1:0]     tan_sel;
   logic [dipc_pkg::OutW-1:0]   mul_a;
   logic [dipc_pkg::QW-1:0]     mul_b;
   logic [62:0]                 prod;
   logic [61:0]                 q;
   logic [dipc_pkg::OutW-1:0]   qsat;

   // denominator, overflow check and screen coordinates
   assign sd       = cfg.depth_step * pix_ff.code;
   assign den_full = {10'b0, cfg.far_plane} - {2'b0, sd};
   assign den_sat  = den_full[40] || (den_full == '0) ||
                     ({15'b0, cfg.far_plane[30:15]} >= den_full[30:0]);
   assign cu       = pix_ff.col * cfg.col_delta;
   assign rv       = pix_ff.row * cfg.row_delta;

   // one restoring division step
   assign rs   = {rem_ff[30:0], num_ff[30]};
   assign fits = rs >= {1'b0, den_ff};

   // shared multiplier, operands chosen by state
   assign axis    = sel_ff ? v_ff : u_ff;
   assign mag     = axis[31] ? dipc_pkg::QW'(-axis) : axis[30:0];
   assign tan_sel = sel_ff ? cfg.tan_half_v : cfg.tan_half_h;
   always_comb begin
      mul_a = {2'b0, p_ff[61:32]};
      mul_b = tan_sel;
      case (state_ff)
         dipc_pkg::B_MP: begin
            mul_a = {1'b0, depth_ff};
            mul_b = mag;
         end
         dipc_pkg::B_ML: begin
            mul_a = p_ff[31:0];
         end
         default: begin
         end
      endcase
   end
   assign prod = mul_a * mul_b;
   assign q    = prod[61:0] + {31'b0, lo_ff};

   // saturate the scaled triple product
   always_comb begin
      if (!neg_ff) begin
         qsat = (q > {30'b0, dipc_pkg::SAT_POS}) ? dipc_pkg::SAT_POS : q[31:0];
      end else begin
         qsat = (q >= {30'b0, dipc_pkg::SAT_NEG}) ? dipc_pkg::SAT_NEG : -q[31:0];
      end
   end

   assign load_out = (state_ff == dipc_pkg::B_OUT) && (!out_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dipc_pkg::B_IDLE: if (fifo_not_empty) state_in = dipc_pkg::B_DEN;
         dipc_pkg::B_DEN:  state_in = den_sat ? dipc_pkg::B_MP : dipc_pkg::B_DIV;
         dipc_pkg::B_DIV:  if (cnt_ff == '0) state_in = dipc_pkg::B_MP;
         dipc_pkg::B_MP:   state_in = dipc_pkg::B_ML;
         dipc_pkg::B_ML:   state_in = dipc_pkg::B_MH;
         dipc_pkg::B_MH:   state_in = sel_ff ? dipc_pkg::B_OUT : dipc_pkg::B_MP;
         dipc_pkg::B_OUT:  if (load_out) state_in = dipc_pkg::B_IDLE;
         default:          state_in = dipc_pkg::B_IDLE;
      endcase
   end

   // datapath updates per state
   always_comb begin
      pop      = 1'b0;
      pix_in   = pix_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      depth_in = depth_ff;
      cnt_in   = cnt_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      p_in     = p_ff;
      neg_in   = neg_ff;
      sel_in   = sel_ff;
      lo_in    = lo_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      unique case (state_ff)
         dipc_pkg::B_IDLE: begin
            pop    = fifo_not_empty;
            pix_in = fifo_data;
         end
         dipc_pkg::B_DEN: begin
            den_in = den_full[30:0];
            u_in   = {2'b0, cu} - dipc_pkg::Q_ONE;
            v_in   = dipc_pkg::Q_ONE - {2'b0, rv};
            sel_in = 1'b0;
            rem_in = {16'b0, cfg.far_plane[30:15]};
            num_in = {cfg.far_plane[14:0], 16'b0};
            cnt_in = dipc_pkg::DivCntW'(dipc_pkg::DivSteps - 1);
            depth_in = den_sat ? dipc_pkg::SAT_POS[30:0] : '0;
         end
         dipc_pkg::B_DIV: begin
            rem_in   = fits ? rs - {1'b0, den_ff} : rs;
            num_in   = {num_ff[29:0], 1'b0};
            depth_in = {depth_ff[29:0], fits};
            cnt_in   = cnt_ff - 1'b1;
         end
         dipc_pkg::B_MP: begin
            p_in   = prod[61:0];
            neg_in = axis[31];
         end
         dipc_pkg::B_ML: begin
            lo_in = prod[62:32];
         end
         dipc_pkg::B_MH: begin
            if (sel_ff) begin
               z_in = qsat;
            end else begin
               y_in = qsat;
            end
            sel_in = !sel_ff;
         end
         dipc_pkg::B_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // result register handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dipc_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff   <= pix_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      depth_ff <= depth_in;
      cnt_ff   <= cnt_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      p_ff     <= p_in;
      neg_ff   <= neg_in;
      sel_ff   <= sel_in;
      lo_ff    <= lo_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      if (load_out) begin
         x_out_ff <= {1'b0, depth_ff};
         y_out_ff <= y_ff;
         z_out_ff <= z_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign x_pos      = x_out_ff;
   assign y_pos      = y_out_ff;
   assign z_pos      = z_out_ff;

`ifndef NO_ASSERTIONS
   // a new pixel is only taken from idle
   a_den_from_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == dipc_pkg::B_DEN |-> $past(state_ff) == dipc_pkg::B_IDLE)
      else $error("denominator stage entered from wrong state");

   // division ends after the last step
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dipc_pkg::B_DIV && cnt_ff == '0) |=> state_ff == dipc_pkg::B_MP)
      else $error("division did not finish");

   // forward distance is never negative
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !x_pos[31])
      else $error("negative forward distance");

   // pop happens only with data in the queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> fifo_not_empty)
      else $error("pop from empty queue");
`endif

endmodule
